[rtl/ggafx_pkg.sv]
// ----------------------------------------------------------------------------
// ggafx_pkg: shared types and constants for the GGA field extractor
// Phase and result-kind codes, the result record and the header text.
// ----------------------------------------------------------------------------
package ggafx_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned HdrLen     = 6;
   localparam int unsigned PosCommas  = 4;
   localparam int unsigned SkipCommas = 3;

   localparam logic [7:0] Comma     = 8'h2C;
   localparam logic [7:0] AsciiZero = 8'h30;

   // rsp_tdata: character [7:0], part [9:8], fix_value [18:10], zero pad to 24 bits
   localparam int unsigned RspDataWidth = 24;
   localparam int unsigned KindWidth    = 3;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_SKIP1  = 3'd1,
      PH_TIME   = 3'd2,
      PH_POS    = 3'd3,
      PH_FIX    = 3'd4,
      PH_SKIP3  = 3'd5,
      PH_ELEV   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      K_TIME     = 3'd0,
      K_POS      = 3'd1,
      K_ELEV     = 3'd2,
      K_DONE     = 3'd3,
      K_MISMATCH = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         character;
      logic [1:0]         part;
      logic signed [8:0]  fix_value;
   } result_type;

   // expected header text "$GNGGA"
   function automatic logic [7:0] hdr_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h24;  // '$'
         3'd1:    c = 8'h47;  // 'G'
         3'd2:    c = 8'h4E;  // 'N'
         3'd3:    c = 8'h47;  // 'G'
         3'd4:    c = 8'h47;  // 'G'
         3'd5:    c = 8'h41;  // 'A'
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[rtl/ggafx_in_reg.sv]
// ----------------------------------------------------------------------------
// ggafx_in_reg: input byte register
// Holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module ggafx_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   output logic       out_valid,
   input  logic       out_take,
   output logic [7:0] out_byte
);
   import ggafx_pkg::*;

   logic                 valid_ff, valid_in;
   logic [ByteWidth-1:0] byte_ff;

   // free slot, or the held byte leaves this cycle
   assign in_ready = !valid_ff || out_take;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;

endmodule

[rtl/ggafx_parser.sv]
// ----------------------------------------------------------------------------
// ggafx_parser: GGA sentence phase machine
// Advances the parse state by one byte and forms at most one result.
// ----------------------------------------------------------------------------
module ggafx_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            byte_in,
   output logic                  emit,
   output ggafx_pkg::result_type result
);
   import ggafx_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [2:0] hdr_count_ff, hdr_count_in;
   logic       hdr_good_ff, hdr_good_in;
   logic [2:0] comma_count_ff, comma_count_in;
   logic [7:0] held_fix_ff, held_fix_in;

   logic       hdr_good_now;
   logic [2:0] comma_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         hdr_count_ff   <= '0;
         hdr_good_ff    <= 1'b1;
         comma_count_ff <= '0;
         held_fix_ff    <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         hdr_count_ff   <= hdr_count_in;
         hdr_good_ff    <= hdr_good_in;
         comma_count_ff <= comma_count_in;
         held_fix_ff    <= held_fix_in;
      end
   end

   assign hdr_good_now = hdr_good_ff && (byte_in == hdr_char(hdr_count_ff));
   assign comma_inc    = comma_count_ff + 3'd1;

   always_comb begin
      phase_in         = phase_ff;
      hdr_count_in     = hdr_count_ff;
      hdr_good_in      = hdr_good_ff;
      comma_count_in   = comma_count_ff;
      held_fix_in      = held_fix_ff;
      emit             = 1'b0;
      result.kind      = K_TIME;
      result.character = '0;
      result.part      = '0;
      result.fix_value = '0;

      unique case (phase_ff)
         PH_HEADER: begin
            if (hdr_count_ff >= 3'(HdrLen)) begin
               hdr_count_in   = '0;
               hdr_good_in    = 1'b1;
               comma_count_in = '0;
            end else if (hdr_count_ff == 3'(HdrLen - 1)) begin
               // last header byte: verdict
               if (hdr_good_now) begin
                  phase_in     = PH_SKIP1;
                  hdr_count_in = '0;
                  hdr_good_in  = 1'b1;
               end else begin
                  hdr_count_in   = '0;
                  hdr_good_in    = 1'b1;
                  comma_count_in = '0;
                  emit           = 1'b1;
                  result.kind    = K_MISMATCH;
               end
            end else begin
               hdr_good_in  = hdr_good_now;
               hdr_count_in = hdr_count_ff + 3'd1;
            end
         end
         PH_SKIP1: begin
            phase_in = PH_TIME;
         end
         PH_TIME: begin
            if (byte_in == Comma) begin
               phase_in       = PH_POS;
               comma_count_in = '0;
            end else begin
               emit             = 1'b1;
               result.kind      = K_TIME;
               result.character = byte_in;
            end
         end
         PH_POS: begin
            if (byte_in == Comma) begin
               if (comma_inc >= 3'(PosCommas)) begin
                  phase_in       = PH_FIX;
                  comma_count_in = '0;
               end else begin
                  comma_count_in = comma_inc;
               end
            end else begin
               emit             = 1'b1;
               result.kind      = K_POS;
               result.character = byte_in;
               result.part      = comma_count_ff[1:0];
            end
         end
         PH_FIX: begin
            held_fix_in    = byte_in;
            comma_count_in = '0;
            phase_in       = PH_SKIP3;
         end
         PH_SKIP3: begin
            if (byte_in == Comma) begin
               if (comma_inc >= 3'(SkipCommas)) begin
                  phase_in       = PH_ELEV;
                  comma_count_in = '0;
               end else begin
                  comma_count_in = comma_inc;
               end
            end
         end
         PH_ELEV: begin
            if (byte_in == Comma) begin
               phase_in         = PH_HEADER;
               hdr_count_in     = '0;
               hdr_good_in      = 1'b1;
               comma_count_in   = '0;
               emit             = 1'b1;
               result.kind      = K_DONE;
               result.fix_value = $signed({1'b0, held_fix_ff} - {1'b0, AsciiZero});
            end else begin
               emit             = 1'b1;
               result.kind      = K_ELEV;
               result.character = byte_in;
            end
         end
         default: begin
            // unused phase code: drop the byte and rearm
            phase_in       = PH_HEADER;
            hdr_count_in   = '0;
            hdr_good_in    = 1'b1;
            comma_count_in = '0;
         end
      endcase
   end

endmodule

[rtl/ggafx_out_reg.sv]
// ----------------------------------------------------------------------------
// ggafx_out_reg: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ggafx_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   output logic                  load_ready,
   input  ggafx_pkg::result_type load_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ggafx_pkg::result_type out_data
);
   import ggafx_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign load_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load_ready) begin
         valid_in = load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/nmea_gga_field_extractor.sv]
// Takes one sentence byte per transfer on req_ and, after a "$GNGGA" header,
// streams the time, position and elevation characters on rsp_, then a done
// result carrying the fix byte less 48, or a mismatch result for a bad header.
// One byte is accepted every clock while the result register can take what
// the parser yields; a byte is held in the input byte register until the parser
// steps on it, and its result is then registered in the result register. Bytes
// that cause no result (header, commas, skipped fields) still take a parser step.
// ----------------------------------------------------------------------------
// nmea_gga_field_extractor: GGA sentence field extractor
// Input byte register, phase machine and result register in one pass.
// ----------------------------------------------------------------------------
module nmea_gga_field_extractor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ggafx_pkg::ByteWidth-1:0]     req_tdata,   // [7:0] byte_in
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ggafx_pkg::RspDataWidth-1:0]  rsp_tdata,   // [7:0] character,
                                                            // [9:8] part,
                                                            // [18:10] fix_value
   output logic [ggafx_pkg::KindWidth-1:0]     rsp_tuser    // [2:0] kind
);
   import ggafx_pkg::*;

   logic       byte_valid;
   logic [7:0] byte_q;
   logic       step;
   logic       emit;
   logic       res_ready;
   result_type result;
   result_type rsp_res;

   // a byte is parsed when the result register can take whatever it yields
   assign step = byte_valid && res_ready;

   ggafx_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .out_valid (byte_valid),
      .out_take  (step),
      .out_byte  (byte_q)
   );

   ggafx_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .byte_in (byte_q),
      .emit    (emit),
      .result  (result)
   );

   ggafx_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (byte_valid && emit),
      .load_ready (res_ready),
      .load_data  (result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_res)
   );

   assign rsp_tdata = {5'b0, rsp_res.fix_value, rsp_res.part, rsp_res.character};
   assign rsp_tuser = rsp_res.kind;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for nmea_gga_field_extractor
// Streams "$GNGGA" sentences with random field content, corrupted headers and
// raw noise into the extractor. Senders and receivers idle and stall at random.
// A byte-level model of the sentence parser predicts every result, and each
// transfer on the result side is compared field by field with the prediction.
// ----------------------------------------------------------------------------
module testbench;
   import ggafx_pkg::*;

   localparam logic [47:0] GGA_HEADER = "$GNGGA";

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ByteWidth-1:0]    req_tdata  = '0;   // [7:0] byte_in
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;         // [7:0] character, [9:8] part,
                                               // [18:10] fix_value
   logic [KindWidth-1:0]    rsp_tuser;         // [2:0] kind

   // sentence bytes waiting to go out, and results the parser should produce
   logic [7:0]  sentence_bytes[$];
   result_type  expected_fields[$];

   // parser model state
   phase_type   ph;
   logic [2:0]  hdr_seen;
   logic        hdr_ok;
   logic [2:0]  commas;
   logic [7:0]  fix_byte;

   int          burst_left;
   int          gap_left;
   int          rx_mode;
   int          rx_cycle;
   int          hold_left;
   bit          hold_done;
   int          results_seen;
   int          errors;
   result_type  want;

   nmea_gga_field_extractor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   task automatic gga_rearm();
      ph       = PH_HEADER;
      hdr_seen = 3'd0;
      hdr_ok   = 1'b1;
      commas   = 3'd0;
   endtask

   // one received byte through the parser model; queues the result if any
   task automatic gga_step(input logic [7:0] b);
      result_type r;
      logic       emit;
      emit        = 1'b0;
      r.kind      = K_TIME;
      r.character = 8'h00;
      r.part      = 2'd0;
      r.fix_value = 9'sd0;
      case (ph)
         PH_HEADER: begin
            if (hdr_seen >= HdrLen) begin
               gga_rearm();
            end else begin
               if (b != GGA_HEADER[47 - 8*hdr_seen -: 8])
                  hdr_ok = 1'b0;
               hdr_seen = hdr_seen + 3'd1;
               if (hdr_seen == HdrLen) begin
                  if (hdr_ok) begin
                     ph       = PH_SKIP1;
                     hdr_seen = 3'd0;
                  end else begin
                     gga_rearm();
                     emit   = 1'b1;
                     r.kind = K_MISMATCH;
                  end
               end
            end
         end
         PH_SKIP1: ph = PH_TIME;
         PH_TIME: begin
            if (b == Comma) begin
               ph     = PH_POS;
               commas = 3'd0;
            end else begin
               emit        = 1'b1;
               r.kind      = K_TIME;
               r.character = b;
            end
         end
         PH_POS: begin
            if (b == Comma) begin
               commas = commas + 3'd1;
               if (commas >= PosCommas) begin
                  ph     = PH_FIX;
                  commas = 3'd0;
               end
            end else begin
               emit        = 1'b1;
               r.kind      = K_POS;
               r.character = b;
               r.part      = commas[1:0];
            end
         end
         PH_FIX: begin
            fix_byte = b;
            commas   = 3'd0;
            ph       = PH_SKIP3;
         end
         PH_SKIP3: begin
            if (b == Comma) begin
               commas = commas + 3'd1;
               if (commas >= SkipCommas) begin
                  ph     = PH_ELEV;
                  commas = 3'd0;
               end
            end
         end
         PH_ELEV: begin
            emit = 1'b1;
            if (b == Comma) begin
               r.kind      = K_DONE;
               r.fix_value = {1'b0, fix_byte} - {1'b0, AsciiZero};
               gga_rearm();
            end else begin
               r.kind      = K_ELEV;
               r.character = b;
            end
         end
         default: gga_rearm();
      endcase
      if (emit)
         expected_fields.push_back(r);
   endtask

   task automatic put_field(input int unsigned len);
      logic [7:0] c;
      for (int i = 0; i < len; i++) begin
         c = 8'($urandom_range(0, 255));
         while (c == Comma)
            c = 8'($urandom_range(0, 255));
         sentence_bytes.push_back(c);
      end
   endtask

   // bad_at < 0 gives a clean header, else that byte is corrupted
   task automatic put_header(input int bad_at);
      logic [7:0] c;
      logic [7:0] flip;
      for (int i = 0; i < HdrLen; i++) begin
         c = GGA_HEADER[47 - 8*i -: 8];
         if (i == bad_at) begin
            flip = 8'($urandom_range(1, 255));
            c    = c ^ flip;
         end
         sentence_bytes.push_back(c);
      end
   endtask

   task automatic put_sentence();
      logic [7:0] f;
      put_header(-1);
      sentence_bytes.push_back(8'($urandom_range(0, 255)));
      put_field($urandom_range(0, 10));
      sentence_bytes.push_back(Comma);
      for (int i = 0; i < PosCommas; i++) begin
         put_field($urandom_range(0, 12));
         sentence_bytes.push_back(Comma);
      end
      case ($urandom_range(0, 9))
         0:       f = 8'h00;
         1:       f = 8'hFF;
         2:       f = Comma;
         3:       f = 8'($urandom_range(0, 255));
         default: f = AsciiZero + 8'($urandom_range(0, 9));
      endcase
      sentence_bytes.push_back(f);
      for (int i = 0; i < SkipCommas; i++) begin
         put_field($urandom_range(0, 4));
         sentence_bytes.push_back(Comma);
      end
      put_field($urandom_range(0, 8));
      sentence_bytes.push_back(Comma);
   endtask

   initial begin
      // empty position and skipped fields, 0x00 and 0xFF passed through, comma as fix byte
      put_header(-1);
      sentence_bytes.push_back(8'hFF);
      sentence_bytes.push_back(8'h00);
      sentence_bytes.push_back(Comma);
      repeat (PosCommas) sentence_bytes.push_back(Comma);
      sentence_bytes.push_back(Comma);
      repeat (SkipCommas) sentence_bytes.push_back(Comma);
      sentence_bytes.push_back(8'hFF);
      sentence_bytes.push_back(Comma);
      // header mismatch on the first and last bytes
      sentence_bytes.push_back(8'h00);
      for (int i = 1; i < HdrLen - 1; i++)
         sentence_bytes.push_back(GGA_HEADER[47 - 8*i -: 8]);
      sentence_bytes.push_back(8'hFF);

      while (sentence_bytes.size() < 1925) begin
         case ($urandom_range(0, 9))
            7:       put_header($urandom_range(0, HdrLen - 1));
            8:       repeat (HdrLen) sentence_bytes.push_back(8'($urandom_range(0, 255)));
            default: put_sentence();
         endcase
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (sentence_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("nmea_gga_field_extractor regression: pass");
      else
         $display("nmea_gga_field_extractor regression: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("nmea_gga_field_extractor regression: fail");
      $finish;
   end

   // sender: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gga_rearm();
         fix_byte   = 8'h00;
         burst_left = $urandom_range(1, 40);
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready)
            gga_step(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (sentence_bytes.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= sentence_bytes.pop_front();
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each transfer and stalls in stretches of its own
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_fields.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, got kind %0d data %06h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_fields.pop_front();
               if (rsp_tuser != want.kind || rsp_tdata[7:0] != want.character ||
                   rsp_tdata[9:8] != want.part || rsp_tdata[18:10] != want.fix_value ||
                   rsp_tdata[RspDataWidth-1:19] != '0) begin
                  errors++;
                  $display("%0t: result mismatch: expected kind %0d char %02h part %0d fix %0d",
                           $time, want.kind, want.character, want.part, want.fix_value);
                  $display("%0t:                  actual kind %0d char %02h part %0d fix %0d pad %0h",
                           $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[9:8],
                           $signed(rsp_tdata[18:10]), rsp_tdata[RspDataWidth-1:19]);
               end
            end
         end

         // one long hold-off so the input side backs up
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= 300) begin
            hold_done = 1'b1;
            hold_left = 300;
            rsp_tready <= 1'b0;
         end else begin
            if (rx_cycle % 64 == 0)
               rx_mode = $urandom_range(0, 2);
            rx_cycle++;
            case (rx_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 1);
               default: rsp_tready <= (rx_cycle % 4 != 0);
            endcase
         end
      end
   end

endmodule

[filelist.f]
rtl/ggafx_pkg.sv
rtl/ggafx_in_reg.sv
rtl/ggafx_parser.sv
rtl/ggafx_out_reg.sv
rtl/nmea_gga_field_extractor.sv
dv/testbench.sv
